// ===== sv/rfge_pkg.sv =====
// shared types and constants for the raster fill and glyph engine
package rfge_pkg;

    localparam int unsigned GlyphWidth  = 8;
    localparam int unsigned GlyphHeight = 16;
    localparam int unsigned GlyphRowBits = 8;
    localparam int unsigned GlyphRows    = 16;

    localparam int unsigned CoordW = 16;
    localparam int unsigned ClipW  = 18;
    localparam int unsigned SizeW  = 15;
    localparam int unsigned ColorW = 32;
    localparam int unsigned AddrW  = 32;

    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned CfgDataW  = 32;

    localparam int unsigned InDataW  = 256;
    localparam int unsigned OutDataW = 64;

    // field positions in s_tdata
    localparam int unsigned PosXLsb   = 0;
    localparam int unsigned PosYLsb   = 16;
    localparam int unsigned RectWLsb  = 32;
    localparam int unsigned RectHLsb  = 47;
    localparam int unsigned ForeLsb   = 62;
    localparam int unsigned BackLsb   = 94;
    localparam int unsigned GTopLsb   = 126;
    localparam int unsigned GBotLsb   = 190;

    typedef enum logic [1:0] {
        OP_STEP  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_FILL  = 2'd2,
        OP_GLYPH = 2'd3
    } opcode_t;

    typedef enum logic [CfgIndexW-1:0] {
        REG_BASE_ADDRESS  = 2'd0,
        REG_ROW_PITCH     = 2'd1,
        REG_SCREEN_WIDTH  = 2'd2,
        REG_SCREEN_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_SOLID = 3'b010,
        MODE_GLYPH = 3'b100
    } walk_mode_t;

endpackage

// ===== sv/raster_fill_and_glyph_engine_unit.sv =====
// raster fill and glyph engine: clipped rectangle and glyph pixel-write walker
// pipeline: an input transfer lands in the input register, and the write that it makes
//   is then held in the output register, where a stall on m_tready can hold it
// throughput: one item per cycle while m_tready does not stall the output; clip compare
//   and a 32x16 row-address multiply share the single processing stage
// reset: synchronous active-low aresetn clears the configuration, walk and valid flags
module raster_fill_and_glyph_engine_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [rfge_pkg::CfgIndexW-1:0]    cfg_index,
    input  logic [rfge_pkg::CfgDataW-1:0]     cfg_wdata,
    // command and step stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pos_x[15:0], pos_y[31:16], rect_width[46:32], rect_height[61:47],
    // fore_color[93:62], back_color[125:94], glyph_top[189:126],
    // glyph_bottom[253:190], zero[255:254]
    input  logic [rfge_pkg::InDataW-1:0]      s_tdata,
    input  logic [1:0]                        s_tuser,   // opcode[1:0]
    // pixel write stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // write_address[31:0], pixel_value[63:32]
    output logic [rfge_pkg::OutDataW-1:0]     m_tdata,
    output logic                              m_tlast    // final_write
);

    // configuration
    logic [31:0] base_address_reg;
    logic [31:0] row_pitch_reg;
    logic [15:0] screen_width_reg;
    logic [15:0] screen_height_reg;

    // input register
    logic                          in_valid_reg;
    logic [rfge_pkg::InDataW-1:0]  in_data_reg;
    logic [1:0]                    in_op_reg;

    // walk state
    rfge_pkg::walk_mode_t walk_mode_reg, walk_mode_next;
    logic [15:0] cur_col_reg, cur_col_next;
    logic [15:0] cur_row_reg, cur_row_next;
    logic [15:0] first_col_reg, first_col_next;
    logic [15:0] end_col_reg, end_col_next;
    logic [15:0] end_row_reg, end_row_next;
    logic signed [15:0] origin_col_reg, origin_col_next;
    logic signed [15:0] origin_row_reg, origin_row_next;
    logic [31:0] row_start_reg, row_start_next;
    logic [31:0] draw_color_reg, draw_color_next;
    logic [31:0] blank_color_reg, blank_color_next;
    logic [rfge_pkg::GlyphRowBits-1:0] glyph_reg [rfge_pkg::GlyphRows];

    // output register
    logic        m_valid_reg;
    logic [63:0] m_data_reg;
    logic        m_last_reg;

    logic advance;
    logic emit;
    logic load_glyph;
    logic [31:0] out_addr;
    logic [31:0] out_pix;
    logic        out_last;

    // command fields
    rfge_pkg::opcode_t op;
    logic signed [15:0] f_pos_x, f_pos_y;
    logic [14:0]        f_rect_w, f_rect_h;
    logic [31:0]        f_fore, f_back;
    logic [63:0]        f_gtop, f_gbot;

    // clipping
    logic signed [rfge_pkg::ClipW-1:0] clip_x, clip_y, clip_w, clip_h;
    logic signed [rfge_pkg::ClipW-1:0] c0, c1, r0, r1, x_end, y_end;
    logic signed [rfge_pkg::ClipW-1:0] scr_w, scr_h;
    logic        clip_empty;
    logic [47:0] row_prod;

    // step
    logic [16:0] col_inc, row_inc;
    logic signed [rfge_pkg::ClipW-1:0] g_row, g_col;
    logic [rfge_pkg::GlyphRowBits-1:0] g_bits;
    logic        g_set;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        op       = rfge_pkg::opcode_t'(in_op_reg);
        f_pos_x  = in_data_reg[rfge_pkg::PosXLsb +: 16];
        f_pos_y  = in_data_reg[rfge_pkg::PosYLsb +: 16];
        f_rect_w = in_data_reg[rfge_pkg::RectWLsb +: 15];
        f_rect_h = in_data_reg[rfge_pkg::RectHLsb +: 15];
        f_fore   = in_data_reg[rfge_pkg::ForeLsb +: 32];
        f_back   = in_data_reg[rfge_pkg::BackLsb +: 32];
        f_gtop   = in_data_reg[rfge_pkg::GTopLsb +: 64];
        f_gbot   = in_data_reg[rfge_pkg::GBotLsb +: 64];

        scr_w = $signed({2'b00, screen_width_reg});
        scr_h = $signed({2'b00, screen_height_reg});

        case (op)
            rfge_pkg::OP_CLEAR: begin
                clip_x = '0;
                clip_y = '0;
                clip_w = scr_w;
                clip_h = scr_h;
            end
            rfge_pkg::OP_GLYPH: begin
                clip_x = rfge_pkg::ClipW'(f_pos_x);
                clip_y = rfge_pkg::ClipW'(f_pos_y);
                clip_w = rfge_pkg::ClipW'(rfge_pkg::GlyphWidth);
                clip_h = rfge_pkg::ClipW'(rfge_pkg::GlyphHeight);
            end
            default: begin
                clip_x = rfge_pkg::ClipW'(f_pos_x);
                clip_y = rfge_pkg::ClipW'(f_pos_y);
                clip_w = $signed({3'b000, f_rect_w});
                clip_h = $signed({3'b000, f_rect_h});
            end
        endcase

        x_end = clip_x + clip_w;
        y_end = clip_y + clip_h;
        c0 = (clip_x < 0) ? '0 : clip_x;
        r0 = (clip_y < 0) ? '0 : clip_y;
        c1 = (x_end < scr_w) ? x_end : scr_w;
        r1 = (y_end < scr_h) ? y_end : scr_h;
        clip_empty = (c0 >= c1) || (r0 >= r1);
        row_prod = row_pitch_reg * r0[15:0];

        // pixel of the current walk position
        col_inc  = {1'b0, cur_col_reg} + 17'd1;
        row_inc  = {1'b0, cur_row_reg} + 17'd1;
        out_addr = row_start_reg + {14'd0, cur_col_reg, 2'b00};
        out_last = (col_inc == {1'b0, end_col_reg}) && (row_inc == {1'b0, end_row_reg});
        g_row = $signed({2'b00, cur_row_reg}) - rfge_pkg::ClipW'(origin_row_reg);
        g_col = $signed({2'b00, cur_col_reg}) - rfge_pkg::ClipW'(origin_col_reg);
        g_bits = (g_row >= 0 && g_row < rfge_pkg::ClipW'(rfge_pkg::GlyphRows))
                 ? glyph_reg[g_row[3:0]] : '0;
        g_set = (g_col >= 0 && g_col < rfge_pkg::ClipW'(rfge_pkg::GlyphRowBits))
                && g_bits[3'(rfge_pkg::GlyphRowBits - 1) - g_col[2:0]];
        out_pix = (walk_mode_reg == rfge_pkg::MODE_GLYPH && !g_set)
                  ? blank_color_reg : draw_color_reg;

        walk_mode_next   = walk_mode_reg;
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        first_col_next   = first_col_reg;
        end_col_next     = end_col_reg;
        end_row_next     = end_row_reg;
        origin_col_next  = origin_col_reg;
        origin_row_next  = origin_row_reg;
        row_start_next   = row_start_reg;
        draw_color_next  = draw_color_reg;
        blank_color_next = blank_color_reg;
        emit       = 1'b0;
        load_glyph = 1'b0;

        if (op == rfge_pkg::OP_STEP) begin
            if (walk_mode_reg != rfge_pkg::MODE_IDLE) begin
                emit = 1'b1;
                if (out_last) begin
                    walk_mode_next = rfge_pkg::MODE_IDLE;
                end else if (col_inc == {1'b0, end_col_reg}) begin
                    cur_col_next   = first_col_reg;
                    cur_row_next   = row_inc[15:0];
                    row_start_next = row_start_reg + row_pitch_reg;
                end else begin
                    cur_col_next = col_inc[15:0];
                end
            end
        end else begin
            draw_color_next = f_fore;
            if (op == rfge_pkg::OP_GLYPH) begin
                blank_color_next = f_back;
                load_glyph       = 1'b1;
            end
            if (clip_empty) begin
                walk_mode_next = rfge_pkg::MODE_IDLE;
            end else begin
                walk_mode_next  = (op == rfge_pkg::OP_GLYPH) ? rfge_pkg::MODE_GLYPH
                                                              : rfge_pkg::MODE_SOLID;
                first_col_next  = c0[15:0];
                cur_col_next    = c0[15:0];
                end_col_next    = c1[15:0];
                cur_row_next    = r0[15:0];
                end_row_next    = r1[15:0];
                origin_col_next = clip_x[15:0];
                origin_row_next = clip_y[15:0];
                row_start_next  = base_address_reg + row_prod[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_address_reg  <= '0;
            row_pitch_reg     <= '0;
            screen_width_reg  <= '0;
            screen_height_reg <= '0;
        end else if (cfg_we) begin
            unique case (rfge_pkg::cfg_reg_t'(cfg_index))
                rfge_pkg::REG_BASE_ADDRESS:  base_address_reg  <= cfg_wdata;
                rfge_pkg::REG_ROW_PITCH:     row_pitch_reg     <= cfg_wdata;
                rfge_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata[15:0];
                rfge_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_op_reg   <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_mode_reg <= rfge_pkg::MODE_IDLE;
        end else if (advance) begin
            walk_mode_reg <= walk_mode_next;
        end
        if (advance) begin
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            first_col_reg   <= first_col_next;
            end_col_reg     <= end_col_next;
            end_row_reg     <= end_row_next;
            origin_col_reg  <= origin_col_next;
            origin_row_reg  <= origin_row_next;
            row_start_reg   <= row_start_next;
            draw_color_reg  <= draw_color_next;
            blank_color_reg <= blank_color_next;
        end
        // the first row of each half sits in that half's top byte
        if (advance && load_glyph) begin
            for (int i = 0; i < rfge_pkg::GlyphRows / 2; i++) begin
                glyph_reg[i] <= f_gtop[63 - 8 * i -: 8];
                glyph_reg[i + rfge_pkg::GlyphRows / 2] <= f_gbot[63 - 8 * i -: 8];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && emit) begin
            m_data_reg <= {out_pix, out_addr};
            m_last_reg <= out_last;
        end
    end

endmodule
